### rtl/core/dspv_pkg.sv
package dspv_pkg;

  localparam int BufferBytesDefault = 12;

  localparam int SegW    = 24;
  localparam int ResW    = 9;
  localparam int DayW    = 5;
  localparam int MonthW  = 4;

  localparam logic [SegW-1:0] YEAR_MAX = 24'd9999999;
  localparam logic [SegW-1:0] SEG_CAP  = 24'd10000000;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2d;

  // position of the leading-dash detector
  typedef enum logic [2:0] {
    LEAD_START = 3'b001,
    LEAD_DASH  = 3'b010,
    LEAD_BODY  = 3'b100
  } lead_t;

  // days in a month, month already known to be 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // next value mod 400 of a digit run, from the current residue and a digit
  function automatic logic [ResW-1:0] mod400_step(input logic [ResW-1:0] r,
                                                   input logic [3:0] d);
    logic [11:0] v;
    v = 12'(r) * 12'd10 + 12'(d);
    if (v >= 12'd3200) v = v - 12'd3200;
    if (v >= 12'd1600) v = v - 12'd1600;
    if (v >= 12'd800)  v = v - 12'd800;
    if (v >= 12'd400)  v = v - 12'd400;
    return v[ResW-1:0];
  endfunction

endpackage

### rtl/core/date_string_parse_validate.sv
// Date string parser. Takes one character per in_ beat (in_tdata) and closes the
// string with a beat that has in_tlast set; that beat's character is ignored. Forms
// YYYY-MM-DD and --MM-DD are accepted; every end beat gives exactly one result beat
// carrying the valid flag in out_tuser and day, month and year in out_tdata, all
// fields zero when the string is not a valid Gregorian date. A beat is taken every
// cycle that in_tready is high: each character is folded into the running segment
// value and its mod-400 residue in the cycle it arrives, and the result is written
// into the output register when the end beat is taken. in_tready drops only while
// that output register holds a result the sink has not taken.
module date_string_parse_validate #(
  parameter int BUFFER_BYTES = dspv_pkg::BufferBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch[7:0]
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // day[4:0], month[8:5], year[32:9], zero fill
  output logic        out_tuser   // valid_res
);

  localparam int CntW = $clog2(BUFFER_BYTES);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_BYTES - 1);
  localparam int SegW = dspv_pkg::SegW;
  localparam int ResW = dspv_pkg::ResW;

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]         dash_r, dash_nxt;
  dspv_pkg::lead_t    lead_r, lead_nxt;
  logic [SegW-1:0]    year_r, year_nxt;
  logic [ResW-1:0]    year_res_r, year_res_nxt;
  logic [SegW-1:0]    month_r, month_nxt;
  logic [SegW-1:0]    seg_r, seg_nxt;
  logic [ResW-1:0]    seg_res_r, seg_res_nxt;
  logic               empty_r, empty_nxt;
  logic               err_r, err_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               res_ok_r;
  logic [4:0]         res_day_r;
  logic [3:0]         res_month_r;
  logic [SegW-1:0]    res_year_r;

  logic               in_acc;
  logic               is_digit, is_dash, skip;
  logic [3:0]         digit;
  logic [26:0]        seg_mul;
  logic               leap, date_ok, ok;
  logic [4:0]         mlen;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= dspv_pkg::CH_ZERO) && (in_tdata <= dspv_pkg::CH_NINE);
  assign is_dash  = (in_tdata == dspv_pkg::CH_DASH);
  assign digit    = 4'(in_tdata - dspv_pkg::CH_ZERO);
  assign seg_mul  = 27'(seg_r) * 27'd10 + 27'(digit);

  // leap year from the year residue mod 400
  assign leap = (year_res_r[1:0] == 2'd0) &&
                ((year_res_r == 9'd0) ||
                 ((year_res_r != 9'd100) && (year_res_r != 9'd200) &&
                  (year_res_r != 9'd300)));
  assign mlen = dspv_pkg::month_len(month_r[3:0], leap);
  assign date_ok = (month_r >= SegW'(1)) && (month_r <= SegW'(12)) &&
                   (seg_r >= SegW'(1)) && (seg_r <= SegW'(mlen)) &&
                   (year_r <= dspv_pkg::YEAR_MAX);
  assign ok = !err_r && (cnt_r != '0) && (dash_r == 2'd2) && !empty_r && date_ok;

  always_comb begin
    cnt_nxt      = cnt_r;
    dash_nxt     = dash_r;
    lead_nxt     = lead_r;
    year_nxt     = year_r;
    year_res_nxt = year_res_r;
    month_nxt    = month_r;
    seg_nxt      = seg_r;
    seg_res_nxt  = seg_res_r;
    empty_nxt    = empty_r;
    err_nxt      = err_r;
    skip         = 1'b0;
    if (in_acc) begin
      if (in_tlast) begin
        cnt_nxt      = '0;
        dash_nxt     = 2'd0;
        lead_nxt     = dspv_pkg::LEAD_START;
        year_nxt     = '0;
        year_res_nxt = '0;
        month_nxt    = '0;
        seg_nxt      = '0;
        seg_res_nxt  = '0;
        empty_nxt    = 1'b1;
        err_nxt      = 1'b0;
      end else if (cnt_r >= CntMax) begin
        err_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
        unique case (lead_r)
          dspv_pkg::LEAD_START: lead_nxt = is_dash ? dspv_pkg::LEAD_DASH
                                                   : dspv_pkg::LEAD_BODY;
          dspv_pkg::LEAD_DASH: begin
            lead_nxt = dspv_pkg::LEAD_BODY;
            // second dash of an omitted-year prefix
            skip = is_dash;
          end
          default: lead_nxt = lead_r;
        endcase
        if (!skip) begin
          if (is_digit) begin
            seg_nxt     = (seg_mul > 27'(dspv_pkg::SEG_CAP)) ? dspv_pkg::SEG_CAP
                                                              : seg_mul[SegW-1:0];
            seg_res_nxt = dspv_pkg::mod400_step(seg_res_r, digit);
            empty_nxt   = 1'b0;
          end else if (is_dash) begin
            if (dash_r == 2'd3) begin
              err_nxt = 1'b1;
            end else begin
              if (dash_r == 2'd0) begin
                year_nxt     = seg_r;
                year_res_nxt = seg_res_r;
              end else if (dash_r == 2'd1) begin
                month_nxt = seg_r;
              end
              dash_nxt    = dash_r + 2'd1;
              seg_nxt     = '0;
              seg_res_nxt = '0;
              empty_nxt   = 1'b1;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && in_tlast) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      dash_r      <= 2'd0;
      lead_r      <= dspv_pkg::LEAD_START;
      year_r      <= '0;
      year_res_r  <= '0;
      month_r     <= '0;
      seg_r       <= '0;
      seg_res_r   <= '0;
      empty_r     <= 1'b1;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      dash_r      <= dash_nxt;
      lead_r      <= lead_nxt;
      year_r      <= year_nxt;
      year_res_r  <= year_res_nxt;
      month_r     <= month_nxt;
      seg_r       <= seg_nxt;
      seg_res_r   <= seg_res_nxt;
      empty_r     <= empty_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      res_ok_r    <= ok;
      res_day_r   <= ok ? seg_r[4:0] : 5'd0;
      res_month_r <= ok ? month_r[3:0] : 4'd0;
      res_year_r  <= ok ? year_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_ok_r;
  assign out_tdata  = {7'd0, res_year_r, res_month_r, res_day_r};

endmodule

### bench/tb_date_string_parse_validate.sv
module tb_date_string_parse_validate;

  localparam int ClockHalf      = 10;
  localparam int BufLimit       = dspv_pkg::BufferBytesDefault;
  localparam int RandomBeats    = 1130;
  localparam int SinkHoldCycles = 300;
  localparam int TailCycles     = 10;
  localparam int CycleLimit     = 800000;
  localparam int ReportMax      = 10;

  typedef struct packed {
    logic                        ok;
    logic [dspv_pkg::DayW-1:0]   day;
    logic [dspv_pkg::MonthW-1:0] month;
    logic [dspv_pkg::SegW-1:0]   year;
  } date_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // ch[7:0]
  logic        in_tlast   = 1'b0;   // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // day[4:0], month[8:5], year[32:9], zero fill
  logic        out_tuser;           // valid_res

  date_string_parse_validate #(
    .BUFFER_BYTES(BufLimit)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #ClockHalf clk = 1'b1;
    #ClockHalf clk = 1'b0;
  end

  // parser model state
  logic [3:0]                ps_chars;
  logic [1:0]                ps_dashes;
  dspv_pkg::lead_t           ps_lead;
  logic [dspv_pkg::SegW-1:0] ps_year;
  logic [dspv_pkg::SegW-1:0] ps_month;
  logic [dspv_pkg::SegW-1:0] ps_seg;
  logic                      ps_seg_empty;
  logic                      ps_error;

  date_result_t pending_dates[$];

  int cycle_count   = 0;
  int beats_sent    = 0;
  int strings_sent  = 0;
  int dates_checked = 0;
  int valid_dates   = 0;
  int mismatches    = 0;

  bit src_gapless    = 1'b0;
  bit sink_no_stall  = 1'b0;
  bit sink_hold_req  = 1'b0;
  int sink_hold_left = 0;
  int sink_run_left  = 0;
  int sink_gap_left  = 0;

  function automatic void clear_parser_model();
    ps_chars     = '0;
    ps_dashes    = '0;
    ps_lead      = dspv_pkg::LEAD_START;
    ps_year      = '0;
    ps_month     = '0;
    ps_seg       = '0;
    ps_seg_empty = 1'b1;
    ps_error     = 1'b0;
  endfunction

  function automatic bit is_calendar_date(input logic [dspv_pkg::SegW-1:0] d,
                                          input logic [dspv_pkg::SegW-1:0] m,
                                          input logic [dspv_pkg::SegW-1:0] y);
    int unsigned len;
    bit          leap;
    if (m < 1 || m > 12) return 1'b0;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      24'd2: begin
        len = leap ? 29 : 28;
      end
      24'd4, 24'd6, 24'd9, 24'd11: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    if (d < 1 || d > len) return 1'b0;
    return y <= dspv_pkg::YEAR_MAX;
  endfunction

  function automatic void fold_char(input logic [7:0] ch);
    logic [31:0] wide;
    if (ps_chars >= BufLimit - 1) begin
      ps_error = 1'b1;
      return;
    end
    ps_chars = ps_chars + 1'b1;
    if (ps_lead == dspv_pkg::LEAD_DASH) begin
      ps_lead = dspv_pkg::LEAD_BODY;
      // second dash of an omitted year
      if (ch == dspv_pkg::CH_DASH) return;
    end else if (ps_lead == dspv_pkg::LEAD_START) begin
      ps_lead = (ch == dspv_pkg::CH_DASH) ? dspv_pkg::LEAD_DASH : dspv_pkg::LEAD_BODY;
    end
    if (ch >= dspv_pkg::CH_ZERO && ch <= dspv_pkg::CH_NINE) begin
      wide = 32'(ps_seg) * 32'd10 + 32'(ch - dspv_pkg::CH_ZERO);
      ps_seg = (wide > 32'(dspv_pkg::SEG_CAP)) ? dspv_pkg::SEG_CAP
                                               : wide[dspv_pkg::SegW-1:0];
      ps_seg_empty = 1'b0;
    end else if (ch == dspv_pkg::CH_DASH) begin
      if (ps_dashes >= 2'd3) begin
        ps_error = 1'b1;
      end else begin
        if (ps_dashes == 2'd0) ps_year = ps_seg;
        else if (ps_dashes == 2'd1) ps_month = ps_seg;
        ps_dashes = ps_dashes + 1'b1;
        ps_seg = '0;
        ps_seg_empty = 1'b1;
      end
    end else begin
      ps_error = 1'b1;
    end
  endfunction

  function automatic date_result_t close_string();
    date_result_t r;
    r = '0;
    if (!ps_error && ps_chars != 0 && ps_dashes == 2'd2 && !ps_seg_empty &&
        is_calendar_date(ps_seg, ps_month, ps_year)) begin
      r.ok    = 1'b1;
      r.day   = ps_seg[dspv_pkg::DayW-1:0];
      r.month = ps_month[dspv_pkg::MonthW-1:0];
      r.year  = ps_year;
    end
    clear_parser_model();
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(input string what, input date_result_t exp_r,
                                 input date_result_t got_r);
    mismatches++;
    if (mismatches <= ReportMax) begin
      $display("mismatch (%s) at cycle %0d: expected ok=%0d day=%0d month=%0d year=%0d,",
               what, cycle_count, exp_r.ok, exp_r.day, exp_r.month, exp_r.year);
      $display("  got ok=%0d day=%0d month=%0d year=%0d",
               got_r.ok, got_r.day, got_r.month, got_r.year);
    end
  endtask

  // one beat on the input side, model updated once the beat is taken
  task automatic send_beat(input logic [7:0] ch, input logic last);
    int gap;
    gap = src_gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (last) begin
      pending_dates.push_back(close_string());
      strings_sent++;
    end else begin
      fold_char(ch);
    end
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    send_end();
  endtask

  // input goes idle so the last beat is not taken again while waiting
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_string();
    int    kind, i, n, p, r;
    string ys, ms, ds, s;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // noise: digits, dashes and arbitrary bytes
      n = $urandom_range(0, 14);
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 9);
        if (r < 4) send_beat(dspv_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        else if (r < 7) send_beat(dspv_pkg::CH_DASH, 1'b0);
        else send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      send_end();
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        ys = $sformatf("%04d", $urandom_range(0, 9999));
      end
      5: begin
        ys = $sformatf("%04d", $urandom_range(0, 99) * 100);
      end
      6: begin
        ys = $sformatf("%0d", $urandom_range(0, 999));
      end
      7: begin
        ys = $sformatf("%0d", $urandom_range(10000, 9999999));
      end
      8: begin
        ys = "-";  // omitted year form
      end
      default: begin
        ys = $sformatf("%0d", $urandom_range(0, 99999999));
      end
    endcase
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 19);
    p = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 31) : $urandom_range(0, 39);
    if ($urandom_range(0, 4) == 0) begin
      n = 2;
      p = $urandom_range(28, 30);
    end
    ms = $urandom_range(0, 1) ? $sformatf("%02d", n) : $sformatf("%0d", n);
    ds = $urandom_range(0, 1) ? $sformatf("%02d", p) : $sformatf("%0d", p);
    s = {ys, "-", ms, "-", ds};
    if (kind < 30) begin
      // broken sequence: cut short or an extra dash
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, s.len() - 1);
        s = s.substr(0, n - 1);
      end else begin
        p = $urandom_range(1, s.len() - 1);
        s = {s.substr(0, p - 1), "-", s.substr(p, s.len() - 1)};
      end
    end
    send_text(s);
  endtask

  task automatic test_directed();
    send_text("2024-02-29");
    send_text("2023-02-29");
    send_text("2000-02-29");
    send_text("1900-02-29");
    send_text("0000-01-01");
    send_text("--12-31");
    send_text("-05-10");
    send_text("");
    send_text("-");
    send_text("2024-13-01");
    send_text("2024-00-10");
    send_text("2023-04-31");
    send_text("2023-04-30");
    send_text("2024-01-");
    send_text("2023--05");
    send_text("2024-1-2-3");
    send_text("1---1-1");
    send_text("---01-01");
    send_text("9999999-1-1");
    send_text("99999999--1");
    send_text("99999999999");
    send_text("2024-011-0101");
    send_text("2024/01/01");
    // nul and all-ones bytes inside an otherwise good date
    send_beat(8'h32, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text("-01-01");
    send_beat(8'hff, 1'b0);
    send_text("1-1-1");
  endtask

  task automatic test_sink_backpressure();
    int i;
    src_gapless   = 1'b1;
    sink_no_stall = 1'b0;
    sink_hold_req = 1'b1;
    for (i = 0; i < 8; i++) send_random_string();
    src_gapless = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 5; i++) send_random_string();
    wait_for_drain();
    for (i = 0; i < 5; i++) send_random_string();
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) begin
      src_gapless   = ($urandom_range(0, 99) < 15);
      sink_no_stall = ($urandom_range(0, 99) < 10);
      send_random_string();
    end
    src_gapless   = 1'b0;
    sink_no_stall = 1'b0;
  endtask

  // sink side: random stalls, a requested long hold-off counted here
  always @(posedge clk) begin
    if (sink_hold_req) begin
      sink_hold_req  = 1'b0;
      sink_hold_left = SinkHoldCycles;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_tready <= 1'b0;
    end else if (sink_no_stall) begin
      out_tready <= 1'b1;
    end else if (sink_gap_left > 0) begin
      sink_gap_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (sink_run_left > 0) begin
        sink_run_left--;
      end else begin
        sink_run_left = $urandom_range(0, 8);
        sink_gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    date_result_t got_r;
    date_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r.ok    = out_tuser;
      got_r.day   = out_tdata[4:0];
      got_r.month = out_tdata[8:5];
      got_r.year  = out_tdata[32:9];
      if (pending_dates.size() == 0) begin
        report_mismatch("no result expected", '0, got_r);
      end else begin
        exp_r = pending_dates.pop_front();
        if (got_r.ok !== exp_r.ok || got_r.day !== exp_r.day ||
            got_r.month !== exp_r.month || got_r.year !== exp_r.year)
          report_mismatch("field", exp_r, got_r);
        if (exp_r.ok) valid_dates++;
      end
      dates_checked++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_parser_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sink_backpressure();
    test_drain_pause();
    test_random();
    wait_for_drain();
    repeat (TailCycles) @(posedge clk);
    $display("covered %0d strings in %0d beats: directed dates, sink hold-off, drain pause,",
             strings_sent, beats_sent);
    $display("random dates and noise; %0d results checked, %0d valid, %0d mismatches",
             dates_checked, valid_dates, mismatches);
    if (mismatches == 0 && pending_dates.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/dspv_pkg.sv
rtl/core/date_string_parse_validate.sv
bench/tb_date_string_parse_validate.sv
